>>> rtl/ccd_pkg.sv
`timescale 1ns / 1ps

package ccd_pkg;

  localparam int MAX_SAMPLES   = 4096;
  localparam int OVERRANGE_BIT = 0;

  localparam int CODE_W   = 32;
  localparam int LEN_W    = 13;
  localparam int IDX_W    = 12;
  localparam int SUM_W    = 44;
  localparam int HALF_W   = 45;
  localparam int TOTAL_W  = 48;
  localparam int COUNT_W  = 16;
  localparam int BAND_W   = 15;
  localparam int AVG_W    = 30;
  localparam int STEP_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Shared divider: dividend as wide as the offset accumulator, divisor as
  // wide as the update period.
  localparam int DIV_N_W   = TOTAL_W;
  localparam int DIV_D_W   = COUNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_CYCLE = 2'd0,
    CFG_CYCLES_PER_UPDATE = 2'd1,
    CFG_CODE_DEADBAND     = 2'd2,
    CFG_SKIP_DAC_UPDATE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_HALF_GO,
    ST_HALF_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_sts_t;

  localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
  localparam logic [STEP_W-1:0] STEP_UP   = 2'b01;
  localparam logic [STEP_W-1:0] STEP_DOWN = 2'b11;

endpackage

>>> rtl/ccd_if.sv
`timescale 1ns / 1ps

interface ccd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ccd_pkg::CODE_W-1:0] block_code;
  logic                            cds_reversed;

  modport source (output valid, output block_code, output cds_reversed, input ready);
  modport sink   (input valid, input block_code, input cds_reversed, output ready);
endinterface

interface ccd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ccd_pkg::AVG_W-1:0]   average_code;
  logic                               overrange;
  logic                               offset_ready;
  logic signed [ccd_pkg::CODE_W-1:0]  offset_code;
  logic signed [ccd_pkg::STEP_W-1:0]  dac_step;

  modport source (output valid, output average_code, output overrange,
                  output offset_ready, output offset_code, output dac_step,
                  input ready);
  modport sink   (input valid, input average_code, input overrange,
                  input offset_ready, input offset_code, input dac_step,
                  output ready);
endinterface

>>> rtl/chopper_cycle_demodulator.sv
`timescale 1ns / 1ps

// Codes inside a modulator cycle are taken back to back, one per cycle.
// The last code of a cycle runs two 48-step divisions on one shared divider, and a third
// division when a DAC decision is due; the result is registered once they are done.
// Input ready stays low from the last code of a cycle until the result is loaded, and
// a full output register holds it off.
// Reset (synchronous, rst_n low): defaults load, accumulators and sign pipeline clear.
module chopper_cycle_demodulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccd_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  ccd_in_if.sink                           in_chan,
  ccd_out_if.source                        out_chan
);

  // Configuration registers
  logic [ccd_pkg::LEN_W-1:0]   spc_r;
  logic [ccd_pkg::COUNT_W-1:0] cpu_r;
  logic [ccd_pkg::BAND_W-1:0]  band_r;
  logic                        skip_r;

  // Cycle accumulators and sequencing state
  ccd_pkg::state_t                    state_r, state_nxt;
  logic [ccd_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [ccd_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [ccd_pkg::HALF_W-1:0]  half_r, half_nxt;
  logic                               ovr_seen_r, ovr_seen_nxt;
  logic                               sign_cur_r, sign_cur_nxt;
  logic                               sign_next_r, sign_next_nxt;
  logic                               rev_r, rev_nxt;
  logic signed [ccd_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [ccd_pkg::COUNT_W-1:0]        ccount_r, ccount_nxt;

  // Staged result
  logic [ccd_pkg::AVG_W-1:0]   st_avg_r, st_avg_nxt;
  logic                        st_ovr_r, st_ovr_nxt;
  logic                        st_rdy_r, st_rdy_nxt;
  logic [ccd_pkg::CODE_W-1:0]  st_off_r, st_off_nxt;
  logic [ccd_pkg::STEP_W-1:0]  st_step_r, st_step_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [ccd_pkg::AVG_W-1:0]   out_avg_r;
  logic                        out_ovr_r;
  logic                        out_rdy_r;
  logic [ccd_pkg::CODE_W-1:0]  out_off_r;
  logic [ccd_pkg::STEP_W-1:0]  out_step_r;
  logic                        out_load;

  ccd_pkg::div_req_t div_req;
  ccd_pkg::div_sts_t div_sts;

  ccd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // Effective cycle length: clamp to 2..MAX_SAMPLES, then drop the low bit.
  logic [ccd_pkg::LEN_W-1:0]   len_clamp;
  logic [ccd_pkg::LEN_W-1:0]   len;
  logic [ccd_pkg::IDX_W-1:0]   half_len;
  logic [ccd_pkg::COUNT_W-1:0] period;

  always_comb begin
    if (spc_r < ccd_pkg::LEN_W'(2)) begin
      len_clamp = ccd_pkg::LEN_W'(2);
    end else if (spc_r > ccd_pkg::LEN_W'(ccd_pkg::MAX_SAMPLES)) begin
      len_clamp = ccd_pkg::LEN_W'(ccd_pkg::MAX_SAMPLES);
    end else begin
      len_clamp = spc_r;
    end
  end

  assign len      = {len_clamp[ccd_pkg::LEN_W-1:1], 1'b0};
  assign half_len = len[ccd_pkg::LEN_W-1:1];
  assign period   = (cpu_r == '0) ? ccd_pkg::COUNT_W'(1) : cpu_r;

  // Input-side arithmetic
  logic                               in_fire;
  logic signed [ccd_pkg::SUM_W-1:0]   code_s;
  logic signed [ccd_pkg::HALF_W-1:0]  code_h;
  logic                               cycle_end;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign code_s    = ccd_pkg::SUM_W'(in_chan.block_code);
  assign code_h    = ccd_pkg::HALF_W'(in_chan.block_code);
  assign cycle_end = ({1'b0, idx_r} >= (len - ccd_pkg::LEN_W'(1)));

  // Magnitudes fed to the divider
  logic [ccd_pkg::SUM_W-1:0]   sum_mag;
  logic [ccd_pkg::HALF_W-1:0]  half_mag;
  logic [ccd_pkg::TOTAL_W-1:0] total_mag;

  assign sum_mag   = sum_r[ccd_pkg::SUM_W-1]   ? ccd_pkg::SUM_W'(-sum_r)     : sum_r;
  assign half_mag  = half_r[ccd_pkg::HALF_W-1] ? ccd_pkg::HALF_W'(-half_r)   : half_r;
  assign total_mag = total_r[ccd_pkg::TOTAL_W-1] ? ccd_pkg::TOTAL_W'(-total_r) : total_r;

  // Post-divide arithmetic
  logic                                 avg_neg;
  logic [ccd_pkg::AVG_W-1:0]            avg_mag;
  logic                                 off_neg;
  logic signed [ccd_pkg::TOTAL_W:0]     off_ext;
  logic signed [ccd_pkg::TOTAL_W:0]     tsum;
  logic signed [ccd_pkg::TOTAL_W-1:0]   tsat;
  logic [ccd_pkg::COUNT_W-1:0]          ccount_inc;
  logic                                 do_update;
  logic                                 mean_neg;
  logic [ccd_pkg::TOTAL_W-1:0]          mean_mag;
  logic                                 mean_big;
  logic [ccd_pkg::CODE_W-1:0]           mean_sat;

  assign avg_neg = sum_r[ccd_pkg::SUM_W-1] ^ sign_cur_r;
  assign avg_mag = div_sts.quotient[ccd_pkg::AVG_W+1:2];

  assign off_neg = half_r[ccd_pkg::HALF_W-1] ^ sign_cur_r;
  assign off_ext = off_neg ? -$signed({3'b000, div_sts.quotient[ccd_pkg::TOTAL_W-1:2]})
                           :  $signed({3'b000, div_sts.quotient[ccd_pkg::TOTAL_W-1:2]});
  assign tsum    = $signed({total_r[ccd_pkg::TOTAL_W-1], total_r}) + off_ext;

  always_comb begin
    if (tsum[ccd_pkg::TOTAL_W] != tsum[ccd_pkg::TOTAL_W-1]) begin
      tsat = tsum[ccd_pkg::TOTAL_W] ? {1'b1, {(ccd_pkg::TOTAL_W-1){1'b0}}}
                                    : {1'b0, {(ccd_pkg::TOTAL_W-1){1'b1}}};
    end else begin
      tsat = tsum[ccd_pkg::TOTAL_W-1:0];
    end
  end

  assign ccount_inc = (ccount_r == '1) ? ccount_r : ccount_r + 1'b1;
  assign do_update  = (ccount_inc >= period) && !skip_r;

  assign mean_neg = total_r[ccd_pkg::TOTAL_W-1];
  assign mean_mag = div_sts.quotient;
  assign mean_big = mean_mag > {{(ccd_pkg::TOTAL_W-ccd_pkg::BAND_W){1'b0}}, band_r};

  always_comb begin
    if (!mean_neg && (mean_mag > ccd_pkg::TOTAL_W'(32'h7FFF_FFFF))) begin
      mean_sat = 32'h7FFF_FFFF;
    end else if (mean_neg && (mean_mag > ccd_pkg::TOTAL_W'(32'h8000_0000))) begin
      mean_sat = 32'h8000_0000;
    end else if (mean_neg) begin
      mean_sat = -mean_mag[ccd_pkg::CODE_W-1:0];
    end else begin
      mean_sat = mean_mag[ccd_pkg::CODE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    half_nxt      = half_r;
    ovr_seen_nxt  = ovr_seen_r;
    sign_cur_nxt  = sign_cur_r;
    sign_next_nxt = sign_next_r;
    rev_nxt       = rev_r;
    total_nxt     = total_r;
    ccount_nxt    = ccount_r;
    st_avg_nxt    = st_avg_r;
    st_ovr_nxt    = st_ovr_r;
    st_rdy_nxt    = st_rdy_r;
    st_off_nxt    = st_off_r;
    st_step_nxt   = st_step_r;
    out_load      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    case (state_r)
      ccd_pkg::ST_IDLE: begin
        if (in_fire) begin
          // Fold the code into both sums and the overrange flag.
          ovr_seen_nxt = ovr_seen_r | in_chan.block_code[ccd_pkg::OVERRANGE_BIT];
          sum_nxt      = sum_r + code_s;
          half_nxt     = (idx_r < half_len) ? half_r + code_h : half_r - code_h;
          if (cycle_end) begin
            rev_nxt   = in_chan.cds_reversed;
            state_nxt = ccd_pkg::ST_SUM_GO;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ccd_pkg::ST_SUM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = ccd_pkg::DIV_N_W'(sum_mag);
        div_req.divisor  = ccd_pkg::DIV_D_W'(len);
        state_nxt        = ccd_pkg::ST_SUM_WAIT;
      end
      ccd_pkg::ST_SUM_WAIT: begin
        if (div_sts.done) begin
          // Quarter the magnitude, then restore the corrected sign.
          st_avg_nxt = avg_neg ? -avg_mag : avg_mag;
          state_nxt  = ccd_pkg::ST_HALF_GO;
        end
      end
      ccd_pkg::ST_HALF_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = ccd_pkg::DIV_N_W'(half_mag);
        div_req.divisor  = ccd_pkg::DIV_D_W'(len);
        state_nxt        = ccd_pkg::ST_HALF_WAIT;
      end
      ccd_pkg::ST_HALF_WAIT: begin
        if (div_sts.done) begin
          total_nxt     = tsat;
          ccount_nxt    = ccount_inc;
          sign_cur_nxt  = sign_next_r;
          sign_next_nxt = rev_r;
          st_ovr_nxt    = ovr_seen_r;
          st_rdy_nxt    = 1'b0;
          st_off_nxt    = '0;
          st_step_nxt   = ccd_pkg::STEP_ZERO;
          // Clear the cycle accumulators for the next modulator cycle.
          idx_nxt       = '0;
          sum_nxt       = '0;
          half_nxt      = '0;
          ovr_seen_nxt  = 1'b0;
          state_nxt     = do_update ? ccd_pkg::ST_MEAN_GO : ccd_pkg::ST_OUT;
        end
      end
      ccd_pkg::ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = total_mag;
        div_req.divisor  = period;
        state_nxt        = ccd_pkg::ST_MEAN_WAIT;
      end
      ccd_pkg::ST_MEAN_WAIT: begin
        if (div_sts.done) begin
          st_rdy_nxt = 1'b1;
          st_off_nxt = mean_sat;
          if (mean_big) begin
            st_step_nxt = mean_neg ? ccd_pkg::STEP_DOWN : ccd_pkg::STEP_UP;
          end else begin
            st_step_nxt = ccd_pkg::STEP_ZERO;
          end
          total_nxt  = '0;
          ccount_nxt = '0;
          state_nxt  = ccd_pkg::ST_OUT;
        end
      end
      ccd_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ccd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r  <= ccd_pkg::LEN_W'(2);
      cpu_r  <= ccd_pkg::COUNT_W'(1);
      band_r <= '0;
      skip_r <= 1'b0;
    end else if (cfg_we) begin
      case (ccd_pkg::cfg_idx_t'(cfg_index))
        ccd_pkg::CFG_SAMPLES_PER_CYCLE: spc_r  <= cfg_wdata[ccd_pkg::LEN_W-1:0];
        ccd_pkg::CFG_CYCLES_PER_UPDATE: cpu_r  <= cfg_wdata[ccd_pkg::COUNT_W-1:0];
        ccd_pkg::CFG_CODE_DEADBAND:     band_r <= cfg_wdata[ccd_pkg::BAND_W-1:0];
        ccd_pkg::CFG_SKIP_DAC_UPDATE:   skip_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccd_pkg::ST_IDLE;
      idx_r       <= '0;
      sum_r       <= '0;
      half_r      <= '0;
      ovr_seen_r  <= 1'b0;
      sign_cur_r  <= 1'b0;
      sign_next_r <= 1'b0;
      total_r     <= '0;
      ccount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      half_r      <= half_nxt;
      ovr_seen_r  <= ovr_seen_nxt;
      sign_cur_r  <= sign_cur_nxt;
      sign_next_r <= sign_next_nxt;
      total_r     <= total_nxt;
      ccount_r    <= ccount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rev_r     <= rev_nxt;
    st_avg_r  <= st_avg_nxt;
    st_ovr_r  <= st_ovr_nxt;
    st_rdy_r  <= st_rdy_nxt;
    st_off_r  <= st_off_nxt;
    st_step_r <= st_step_nxt;
    if (out_load) begin
      out_avg_r  <= st_avg_r;
      out_ovr_r  <= st_ovr_r;
      out_rdy_r  <= st_rdy_r;
      out_off_r  <= st_off_r;
      out_step_r <= st_step_r;
    end
  end

  assign in_chan.ready         = (state_r == ccd_pkg::ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.average_code = out_avg_r;
  assign out_chan.overrange    = out_ovr_r;
  assign out_chan.offset_ready = out_rdy_r;
  assign out_chan.offset_code  = out_off_r;
  assign out_chan.dac_step     = out_step_r;

  // Never restart the divider while it is still iterating.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // The last code of a modulator cycle must launch the sum division.
  a_cycle_end_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cycle_end) |=> (state_r == ccd_pkg::ST_SUM_GO))
    else $error("cycle end did not start division");

  // Without a completed averaging period the offset and step read zero.
  a_no_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rdy_r) |-> (out_off_r == '0 && out_step_r == ccd_pkg::STEP_ZERO))
    else $error("offset fields set without offset_ready");

  // A DAC step is only -1, 0 or +1.
  a_step_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_step_r != 2'b10))
    else $error("illegal dac step");

endmodule

>>> rtl/ccd_divider.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module ccd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  ccd_pkg::div_req_t req,
  output ccd_pkg::div_sts_t sts
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [ccd_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ccd_pkg::DIV_D_W-1:0]     rem_r, rem_nxt;
  logic [ccd_pkg::DIV_D_W-1:0]     dvs_r, dvs_nxt;
  logic [ccd_pkg::DIV_N_W-1:0]     quo_r, quo_nxt;

  logic [ccd_pkg::DIV_D_W:0]       shifted;
  logic [ccd_pkg::DIV_D_W:0]       diff;
  logic                            ge;

  assign shifted = {rem_r, quo_r[ccd_pkg::DIV_N_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ccd_pkg::DIV_CNT_W'(ccd_pkg::DIV_N_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[ccd_pkg::DIV_D_W-1:0] : shifted[ccd_pkg::DIV_D_W-1:0];
      quo_nxt = {quo_r[ccd_pkg::DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ccd_pkg::*;

  // One result of a finished modulator cycle, laid out as on the result channel.
  typedef struct packed {
    logic signed [AVG_W-1:0]  average_code;
    logic                     overrange;
    logic                     offset_ready;
    logic signed [CODE_W-1:0] offset_code;
    logic signed [STEP_W-1:0] dac_step;
  } demod_result_t;

  // One request on the input channel.
  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic                     rev;
  } block_req_t;

  localparam logic signed [CODE_W-1:0] CODE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CODE_W-1:0] CODE_MIN = 32'sh8000_0000;
  localparam longint ACC_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN       = -ACC_MAX - 1;
  localparam longint OFS_MAX       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint OFS_MIN       = -OFS_MAX - 1;
  localparam int     HOLD_CYCLES   = 3000;
  // Worst case after the last code of a cycle: the divisions plus output stalls.
  localparam int     SETTLE_CYCLES = 200;
  localparam int     RANDOM_PHASES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  ccd_in_if  in_chan ();
  ccd_out_if out_chan ();

  chopper_cycle_demodulator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests waiting to be offered, and cycle results the block still owes us.
  block_req_t    queued_block_codes[$];
  demod_result_t due_cycle_results[$];
  int unsigned   mismatches = 0;

  // Register copies as the block holds them.
  logic [LEN_W-1:0]   reg_samples;
  logic [COUNT_W-1:0] reg_period;
  logic [BAND_W-1:0]  reg_band;
  logic               reg_skip;

  // Demodulator state: position in cycle, running sums, sign pipeline, offset integrator.
  longint idx_in_cycle = 0;
  longint cycle_sum    = 0;
  longint split_sum    = 0;
  longint offset_acc   = 0;
  longint cycles_acc   = 0;
  logic   ovr_flag     = 1'b0;
  logic   sign_now     = 1'b0;
  logic   sign_pending = 1'b0;

  // Effective cycle length: clamp to [2, MAX_SAMPLES], then drop the low bit.
  function automatic longint cycle_len();
    longint n;
    n = reg_samples;
    if (n < 2) n = 2;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    n = n - (n % 2);
    return n;
  endfunction

  // Advance the demodulator by one accepted code; on the last code of a cycle,
  // queue the result the block has to produce.
  task automatic demodulate_code(input logic signed [CODE_W-1:0] code, input logic rev);
    longint        c;
    longint        len;
    longint        sgn;
    longint        avg;
    longint        off;
    longint        period;
    longint        mean;
    longint        band;
    demod_result_t r;
    c   = code;
    len = cycle_len();
    ovr_flag  = ovr_flag | code[OVERRANGE_BIT];
    cycle_sum = cycle_sum + c;
    // First half adds, second half subtracts; a length change mid-cycle moves the split.
    if (idx_in_cycle < len / 2) split_sum = split_sum + c;
    else split_sum = split_sum - c;
    if (idx_in_cycle < len - 1) begin
      idx_in_cycle = (idx_in_cycle + 1) % (1 << IDX_W);
    end else begin
      // Sign is the CDS bit passed through sign_pending and then sign_now; divisions truncate toward zero.
      sgn = sign_now ? -1 : 1;
      avg = (cycle_sum / len) * sgn;
      off = ((split_sum / len) * sgn) / 4;
      r.average_code = avg / 4;
      r.overrange    = ovr_flag;
      r.offset_ready = 1'b0;
      r.offset_code  = '0;
      r.dac_step     = STEP_ZERO;

      offset_acc = offset_acc + off;
      if (offset_acc > ACC_MAX) offset_acc = ACC_MAX;
      if (offset_acc < ACC_MIN) offset_acc = ACC_MIN;
      if (cycles_acc < 65535) cycles_acc = cycles_acc + 1;

      sign_now     = sign_pending;
      sign_pending = rev;

      period = reg_period;
      if (period == 0) period = 1;
      if (cycles_acc >= period && !reg_skip) begin
        // Deadband compares the unclamped mean; only the reported code saturates.
        mean = offset_acc / period;
        band = reg_band;
        if (mean > band) r.dac_step = STEP_UP;
        if (mean < -band) r.dac_step = STEP_DOWN;
        if (mean > OFS_MAX) mean = OFS_MAX;
        if (mean < OFS_MIN) mean = OFS_MIN;
        r.offset_code  = mean;
        r.offset_ready = 1'b1;
        offset_acc = 0;
        cycles_acc = 0;
      end

      idx_in_cycle = 0;
      cycle_sum    = 0;
      split_sum    = 0;
      ovr_flag     = 1'b0;
      due_cycle_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests in bursts with random gaps; hold the payload
  // while the block stalls, and predict each request at the edge it is taken.
  // ---------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left = 0;
  block_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        demodulate_code(in_chan.block_code, in_chan.cds_reversed);
      // Advance only when the slot is free: nothing offered, or the offer was taken.
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (queued_block_codes.size() != 0) begin
          next_req = queued_block_codes.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.block_code   <= next_req.code;
          in_chan.cds_reversed <= next_req.rev;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a rotating pattern that is redrawn now and then (all ones
  // some of the time), and once hold off for a long stretch so the block fills up.
  // ---------------------------------------------------------------------------
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          pat_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left  = $urandom_range(50, 400);
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(1, 16'hFFFF);
      end
      pat_left--;
      out_chan.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every taken result against the oldest prediction.
  // ---------------------------------------------------------------------------
  demod_result_t want;
  demod_result_t got;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.average_code = out_chan.average_code;
      got.overrange    = out_chan.overrange;
      got.offset_ready = out_chan.offset_ready;
      got.offset_code  = out_chan.offset_code;
      got.dac_step     = out_chan.dac_step;
      if (due_cycle_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: avg=%0d ovr=%0b rdy=%0b ofs=%0d step=%0d",
                   got.average_code, got.overrange, got.offset_ready,
                   got.offset_code, got.dac_step);
        mismatches++;
      end else begin
        want = due_cycle_results.pop_front();
        if (got.average_code !== want.average_code || got.overrange !== want.overrange ||
            got.offset_ready !== want.offset_ready || got.offset_code !== want.offset_code ||
            got.dac_step !== want.dac_step) begin
          if (mismatches < 10) begin
            $display("mismatch: exp avg=%0d ovr=%0b rdy=%0b ofs=%0d step=%0d",
                     want.average_code, want.overrange, want.offset_ready,
                     want.offset_code, want.dac_step);
            $display("          got avg=%0d ovr=%0b rdy=%0b ofs=%0d step=%0d",
                     got.average_code, got.overrange, got.offset_ready,
                     got.offset_code, got.dac_step);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void queue_item(input logic signed [CODE_W-1:0] code, input logic rev);
    block_req_t q;
    q.code = code;
    q.rev  = rev;
    queued_block_codes.push_back(q);
  endfunction

  // Both codes of a shortest modulator cycle; the first carries the opposite CDS bit,
  // which the block must ignore.
  function automatic void queue_pair(input logic signed [CODE_W-1:0] first,
                                     input logic signed [CODE_W-1:0] second,
                                     input logic rev);
    queue_item(first, ~rev);
    queue_item(second, rev);
  endfunction

  // Drive one register write; the block is idle whenever this runs.
  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DAT_W-1:0];
    case (idx)
      CFG_SAMPLES_PER_CYCLE: reg_samples = value[LEN_W-1:0];
      CFG_CYCLES_PER_UPDATE: reg_period  = value[COUNT_W-1:0];
      CFG_CODE_DEADBAND:     reg_band    = value[BAND_W-1:0];
      CFG_SKIP_DAC_UPDATE:   reg_skip    = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned samples, input int unsigned period,
                           input int unsigned band, input int unsigned skip);
    write_reg(CFG_SAMPLES_PER_CYCLE, samples);
    write_reg(CFG_CYCLES_PER_UPDATE, period);
    write_reg(CFG_CODE_DEADBAND, band);
    write_reg(CFG_SKIP_DAC_UPDATE, skip);
  endtask

  // Drain all requests and results, then let any cycle still dividing finish.
  task automatic wait_idle();
    while (queued_block_codes.size() != 0 || in_chan.valid || due_cycle_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                       i;
    int                       ph;
    int unsigned              r;
    int unsigned              samples;
    int unsigned              period;
    int unsigned              band;
    int unsigned              skip;
    int unsigned              style;
    int unsigned              n_items;
    int                       base_i;
    int                       delta_i;
    int                       noise;
    longint                   len;
    longint                   pos;
    logic signed [CODE_W-1:0] c;

    in_chan.valid        = 1'b0;
    in_chan.block_code   = '0;
    in_chan.cds_reversed = 1'b0;
    out_chan.ready       = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults, then extremes, overrange, sign pipeline and truncation toward zero.
    configure(2, 1, 0, 0);
    queue_pair(CODE_MAX, CODE_MAX, 1'b1);
    queue_pair(CODE_MIN, CODE_MIN, 1'b1);
    queue_pair(CODE_MAX, CODE_MIN, 1'b0);
    queue_pair(CODE_MIN, CODE_MAX, 1'b1);
    queue_pair(-32'sd3, 32'sd5, 1'b0);
    queue_pair(-32'sd1, -32'sd1, 1'b0);
    queue_pair(32'sd6, -32'sd6, 1'b0);
    wait_idle();

    // Integrate the largest offset while skipping, then decide: the mean
    // overflows 32 bits and the reported code must saturate.
    configure(2, 1, 0, 1);
    repeat (6) queue_pair(CODE_MAX, CODE_MIN, 1'b0);
    wait_idle();
    configure(2, 1, 0, 0);
    queue_pair(CODE_MAX, CODE_MIN, 1'b0);
    wait_idle();

    // One full cycle at an odd length, rounded down to 512, with wide sums.
    configure(513, 2, 32767, 0);
    for (i = 0; i < 512; i++)
      queue_item((i < 256) ? CODE_MAX : CODE_MIN, $urandom_range(0, 1));
    wait_idle();

    // Random phases, each with a fresh setting of every register.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       samples = 0;
        1:       samples = 1;
        2:       samples = 2 * $urandom_range(1, 3) + 1;
        7:       samples = $urandom_range(17, 64);
        8:       samples = ($urandom_range(0, 1) != 0) ? 8191 : 4097;
        default: samples = $urandom_range(2, 16);
      endcase
      if (ph == 0) samples = 2;
      r = $urandom_range(0, 7);
      case (r)
        0:       period = 0;
        1:       period = 65535;
        default: period = $urandom_range(1, 6);
      endcase
      r = $urandom_range(0, 3);
      case (r)
        0:       band = 0;
        1:       band = 32767;
        2:       band = $urandom_range(0, 200);
        default: band = $urandom_range(0, 32767);
      endcase
      skip = ($urandom_range(0, 4) == 0) ? 1 : 0;
      configure(samples, period, band, skip);

      // Hold the receiver off once while this phase's requests keep coming.
      if (ph == 0) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end

      len     = cycle_len();
      style   = $urandom_range(0, 3);
      base_i  = int'($urandom_range(0, 10000)) - 5000;
      delta_i = int'($urandom_range(0, 6000)) - 3000;
      n_items = $urandom_range(70, 100);
      for (i = 0; i < n_items; i++) begin
        pos   = i % len;
        noise = int'($urandom_range(0, 64)) - 32;
        case (style)
          0: c = $urandom;
          // Split pattern: a steady offset around the deadband drives DAC steps.
          1: c = base_i + ((pos < len / 2) ? delta_i : -delta_i) + noise;
          2: begin
            r = $urandom_range(0, 5);
            case (r)
              0:       c = CODE_MAX;
              1:       c = CODE_MIN;
              2:       c = '0;
              3:       c = -32'sd1;
              4:       c = 32'sd1;
              default: c = $urandom;
            endcase
          end
          default: c = int'($urandom_range(0, 255)) - 128;
        endcase
        queue_item(c, $urandom_range(0, 1));
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ccd_pkg.sv
rtl/ccd_if.sv
rtl/ccd_divider.sv
rtl/chopper_cycle_demodulator.sv
tb/sv/tb.sv
